// ----- rtl/bcpi_pkg.sv -----
// boost converter pi control: shared types, constants and sequencer states
// no dependencies; used by every other file of the block
`default_nettype none

package bcpi_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int TARGET_W   = 10;
    localparam int DUTY_W     = 8;
    localparam int MEAS_W     = 9;
    localparam int GAIN_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int ERR_W      = 11;
    localparam int INTEG_W    = 32;
    localparam int MUL_A_W    = 34;
    localparam int MUL_B_W    = 18;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int KPE_W      = 20;
    localparam int QUOT_W     = 23;
    localparam int DRIVE_W    = 25;

    // floor(x / 3) = (x * 683) >> 11 for x below 1024
    localparam logic [MUL_B_W-1:0] RECIP_3       = MUL_B_W'(683);
    localparam int                 RECIP_3_SHIFT = 11;
    // floor(x / 1000) = (x * 2199023256) >> 41 for x up to 2^31
    localparam logic [MUL_A_W-1:0] RECIP_1000       = MUL_A_W'(64'd2199023256);
    localparam int                 RECIP_1000_SHIFT = 41;

    localparam logic [DRIVE_W-1:0] DUTY_FULL = DRIVE_W'(255);
    localparam logic [DUTY_W-1:0]  DUTY_MAX  = DUTY_W'(DUTY_FULL - 1);
    localparam logic [7:0]         COUNT_MAX = 8'd255;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST    = 8'd7;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST   = 8'd13;
    localparam logic [GAIN_W-1:0] CHECK_PERIOD_RST = 8'd10;
    localparam logic [GAIN_W-1:0] FAULT_LIMIT_RST  = 8'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN    = 2'd0,
        REG_INTEG_GAIN   = 2'd1,
        REG_CHECK_PERIOD = 2'd2,
        REG_FAULT_LIMIT  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integ_gain;
        logic [GAIN_W-1:0] check_period;
        logic [GAIN_W-1:0] fault_limit;
    } cfg_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              failed;
        logic [MEAS_W-1:0] measured_volts;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAS,
        ST_GAIN,
        ST_INTEG,
        ST_ACC,
        ST_DLO,
        ST_DHI,
        ST_OUT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/bcpi_sample_if.sv -----
// input channel: adc sample and target voltage with valid/ready
// depends on bcpi_pkg
`default_nettype none

interface bcpi_sample_if;
    logic                          valid;
    logic                          ready;
    logic [bcpi_pkg::SAMPLE_W-1:0] adc_sample;
    logic [bcpi_pkg::TARGET_W-1:0] target_volts;

    modport source (output valid, output adc_sample, output target_volts, input ready);
    modport sink   (input valid, input adc_sample, input target_volts, output ready);
endinterface

`default_nettype wire

// ----- rtl/bcpi_result_if.sv -----
// output channel: duty, failed flag and measured voltage with valid/ready
// depends on bcpi_pkg
`default_nettype none

interface bcpi_result_if;
    logic                        valid;
    logic                        ready;
    logic [bcpi_pkg::DUTY_W-1:0] duty;
    logic                        failed;
    logic [bcpi_pkg::MEAS_W-1:0] measured_volts;

    modport source (output valid, output duty, output failed, output measured_volts,
                    input ready);
    modport sink   (input valid, input duty, input failed, input measured_volts,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/bcpi_mul.sv -----
// shared signed multiplier with registered product
// depends on bcpi_pkg
`default_nettype none

module bcpi_mul (
    input  wire logic                                 clk,
    input  wire logic signed [bcpi_pkg::MUL_A_W-1:0]  op_a,
    input  wire logic signed [bcpi_pkg::MUL_B_W-1:0]  op_b,
    output logic signed      [bcpi_pkg::MUL_P_W-1:0]  prod
);

    logic signed [bcpi_pkg::MUL_P_W-1:0] prod_reg;
    logic signed [bcpi_pkg::MUL_P_W-1:0] prod_next;

    assign prod_next = op_a * op_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ----- rtl/bcpi_core.sv -----
// pi control sequencer: walks one item through the shared multiplier
// depends on bcpi_pkg and bcpi_mul
`default_nettype none

module bcpi_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire bcpi_pkg::cfg_t                    cfg,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [bcpi_pkg::SAMPLE_W-1:0]     adc_sample,
    input  wire logic [bcpi_pkg::TARGET_W-1:0]     target_volts,
    output logic                                   res_valid,
    input  wire logic                              res_ready,
    output bcpi_pkg::result_t                      res
);

    localparam int AW = bcpi_pkg::MUL_A_W;
    localparam int BW = bcpi_pkg::MUL_B_W;
    localparam int EW = bcpi_pkg::ERR_W;
    localparam int IW = bcpi_pkg::INTEG_W;

    bcpi_pkg::state_t state_reg, state_next;

    logic [bcpi_pkg::SAMPLE_W-1:0] sample_reg;
    logic [bcpi_pkg::TARGET_W-1:0] target_reg;
    logic [bcpi_pkg::MEAS_W-1:0]   meas_reg;
    logic signed [EW-1:0]          err_reg;
    logic signed [IW-1:0]          integ_reg, integ_next;
    logic [7:0]                    fcount_reg, fcount_next;
    logic signed [bcpi_pkg::KPE_W-1:0] kpe_reg;
    logic [47:0]                   lo_reg;
    bcpi_pkg::result_t             res_reg, res_next;

    logic signed [AW-1:0]                   op_a;
    logic signed [BW-1:0]                   op_b;
    logic signed [bcpi_pkg::MUL_P_W-1:0]    prod;

    logic [bcpi_pkg::MEAS_W-1:0]   meas_now;
    logic signed [EW-1:0]          err_now;
    logic signed [BW-1:0]          err_ext;
    logic signed [IW+1:0]          acc_sum;
    logic signed [IW-1:0]          acc_sat;
    logic [IW-1:0]                 integ_abs;
    logic [63:0]                   quot_full;
    logic [bcpi_pkg::QUOT_W-1:0]   quot;
    logic signed [bcpi_pkg::DRIVE_W-1:0] quot_s;
    logic signed [bcpi_pkg::DRIVE_W-1:0] drive;
    logic                          clamp_hi;
    logic                          clamp_lo;
    logic [7:0]                    fcount_inc;

    bcpi_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // datapath
    assign meas_now  = prod[bcpi_pkg::RECIP_3_SHIFT +: bcpi_pkg::MEAS_W];
    assign err_now   = $signed({1'b0, target_reg}) - $signed({2'b00, meas_now});
    assign err_ext   = {{(BW-EW){err_reg[EW-1]}}, err_reg};

    assign acc_sum   = {{2{integ_reg[IW-1]}}, integ_reg} + prod[IW+1:0];
    always_comb
    begin
        if (acc_sum[IW+1:IW-1] == 3'b000 || acc_sum[IW+1:IW-1] == 3'b111)
        begin
            acc_sat = acc_sum[IW-1:0];
        end
        else if (acc_sum[IW+1])
        begin
            acc_sat = {1'b1, {(IW-1){1'b0}}};
        end
        else
        begin
            acc_sat = {1'b0, {(IW-1){1'b1}}};
        end
    end

    assign integ_abs = integ_reg[IW-1] ? (~integ_reg + 1'b1) : integ_reg;

    // high partial product shifted by 16 plus low partial product
    assign quot_full = {prod[47:0], 16'h0000} + {16'h0000, lo_reg};
    assign quot      = quot_full[bcpi_pkg::RECIP_1000_SHIFT +: bcpi_pkg::QUOT_W];
    assign quot_s    = integ_reg[IW-1] ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
    assign drive     = {{(bcpi_pkg::DRIVE_W-bcpi_pkg::KPE_W){kpe_reg[bcpi_pkg::KPE_W-1]}},
                        kpe_reg} + quot_s;
    assign clamp_hi  = (drive >= $signed(bcpi_pkg::DUTY_FULL));
    assign clamp_lo  = drive[bcpi_pkg::DRIVE_W-1];
    assign fcount_inc = (fcount_reg < bcpi_pkg::COUNT_MAX) ? fcount_reg + 8'd1 : fcount_reg;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        op_a        = '0;
        op_b        = '0;
        integ_next  = integ_reg;
        fcount_next = fcount_reg;
        res_next    = res_reg;
        case (state_reg)
            bcpi_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bcpi_pkg::ST_MEAS;
                end
            end
            bcpi_pkg::ST_MEAS:
            begin
                op_a       = {{(AW-bcpi_pkg::SAMPLE_W-2){1'b0}}, sample_reg, 2'b00};
                op_b       = bcpi_pkg::RECIP_3;
                state_next = bcpi_pkg::ST_GAIN;
            end
            bcpi_pkg::ST_GAIN:
            begin
                op_a       = {{(AW-bcpi_pkg::GAIN_W){1'b0}}, cfg.integ_gain};
                op_b       = {{(BW-bcpi_pkg::GAIN_W){1'b0}}, cfg.check_period};
                state_next = bcpi_pkg::ST_INTEG;
            end
            bcpi_pkg::ST_INTEG:
            begin
                op_a       = {{(AW-17){1'b0}}, prod[15:0], 1'b0};
                op_b       = err_ext;
                state_next = bcpi_pkg::ST_ACC;
            end
            bcpi_pkg::ST_ACC:
            begin
                integ_next = acc_sat;
                op_a       = {{(AW-bcpi_pkg::GAIN_W){1'b0}}, cfg.prop_gain};
                op_b       = err_ext;
                state_next = bcpi_pkg::ST_DLO;
            end
            bcpi_pkg::ST_DLO:
            begin
                op_a       = bcpi_pkg::RECIP_1000;
                op_b       = {2'b00, integ_abs[15:0]};
                state_next = bcpi_pkg::ST_DHI;
            end
            bcpi_pkg::ST_DHI:
            begin
                op_a       = bcpi_pkg::RECIP_1000;
                op_b       = {2'b00, integ_abs[31:16]};
                state_next = bcpi_pkg::ST_OUT;
            end
            bcpi_pkg::ST_OUT:
            begin
                res_next.measured_volts = meas_reg;
                if (clamp_hi || clamp_lo)
                begin
                    fcount_next = fcount_inc;
                    if (fcount_inc >= cfg.fault_limit)
                    begin
                        res_next.failed = 1'b1;
                        res_next.duty   = '0;
                    end
                    else
                    begin
                        res_next.failed = 1'b0;
                        res_next.duty   = clamp_hi ? bcpi_pkg::DUTY_MAX : '0;
                    end
                end
                else
                begin
                    fcount_next     = '0;
                    res_next.failed = 1'b0;
                    res_next.duty   = drive[bcpi_pkg::DUTY_W-1:0];
                end
                state_next = bcpi_pkg::ST_DONE;
            end
            bcpi_pkg::ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = bcpi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bcpi_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bcpi_pkg::ST_IDLE;
            integ_reg  <= '0;
            fcount_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            integ_reg  <= integ_next;
            fcount_reg <= fcount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == bcpi_pkg::ST_IDLE && in_valid)
        begin
            sample_reg <= adc_sample;
            target_reg <= target_volts;
        end
        if (state_reg == bcpi_pkg::ST_GAIN)
        begin
            meas_reg <= meas_now;
            err_reg  <= err_now;
        end
        if (state_reg == bcpi_pkg::ST_DLO)
        begin
            kpe_reg <= prod[bcpi_pkg::KPE_W-1:0];
        end
        if (state_reg == bcpi_pkg::ST_DHI)
        begin
            lo_reg <= prod[47:0];
        end
        res_reg <= res_next;
    end

    assign in_ready  = (state_reg == bcpi_pkg::ST_IDLE);
    assign res_valid = (state_reg == bcpi_pkg::ST_DONE);
    assign res       = res_reg;

endmodule

`default_nettype wire

// ----- rtl/boost_converter_pi_control.sv -----
// boost converter pi control top level: configuration registers, core, output register
// depends on bcpi_pkg, bcpi_sample_if, bcpi_result_if and bcpi_core
//
//   channel   kind          payload
//   sample    valid/ready   adc_sample[7:0], target_volts[9:0]
//   result    valid/ready   duty[7:0], failed, measured_volts[8:0]
//   cfg       write only    cfg_we, cfg_index[1:0], cfg_data[7:0]
//
// each item passes in order through six steps on the single shared multiplier, one output step,
// the handoff to the output register and the idle state that takes the next sample
// the result sits in an output register, so a new sample is taken while it waits
// rst_n clears the sequencer, integrator, fault count and loads register defaults
// a result not yet taken holds the core in its final step until the register frees
`default_nettype none

module boost_converter_pi_control (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    bcpi_sample_if.sink                             sample,
    bcpi_result_if.source                           result,
    input  wire logic                               cfg_we,
    input  wire logic [bcpi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bcpi_pkg::GAIN_W-1:0]        cfg_data
);

    bcpi_pkg::cfg_t    cfg_reg;
    bcpi_pkg::result_t core_res;
    bcpi_pkg::result_t out_reg;
    logic              out_valid_reg;
    logic              core_valid;
    logic              core_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain    <= bcpi_pkg::PROP_GAIN_RST;
            cfg_reg.integ_gain   <= bcpi_pkg::INTEG_GAIN_RST;
            cfg_reg.check_period <= bcpi_pkg::CHECK_PERIOD_RST;
            cfg_reg.fault_limit  <= bcpi_pkg::FAULT_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (bcpi_pkg::cfg_index_t'(cfg_index))
                bcpi_pkg::REG_PROP_GAIN:    cfg_reg.prop_gain    <= cfg_data;
                bcpi_pkg::REG_INTEG_GAIN:   cfg_reg.integ_gain   <= cfg_data;
                bcpi_pkg::REG_CHECK_PERIOD: cfg_reg.check_period <= cfg_data;
                bcpi_pkg::REG_FAULT_LIMIT:  cfg_reg.fault_limit  <= cfg_data;
                default:                    cfg_reg              <= cfg_reg;
            endcase
        end
    end

    bcpi_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (sample.valid),
        .in_ready     (sample.ready),
        .adc_sample   (sample.adc_sample),
        .target_volts (sample.target_volts),
        .res_valid    (core_valid),
        .res_ready    (core_ready),
        .res          (core_res)
    );

    // output register frees when empty or being taken
    assign core_ready = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (core_ready)
        begin
            out_valid_reg <= core_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_ready && core_valid)
        begin
            out_reg <= core_res;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.duty           = out_reg.duty;
    assign result.failed         = out_reg.failed;
    assign result.measured_volts = out_reg.measured_volts;

endmodule

`default_nettype wire
